### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the stuffed frame decoder.
// The SYNTH branch leaves every macro empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every edge outside reset
`define SFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SFD_ASSERT(lbl, clk, rst, prop, msg)
`define SFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the stuffed frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // data widths
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int LEN_W    = 9;
   localparam int CSR_IDX_W = 2;

   // default limits and queue depths
   localparam int MAX_LEN_DEFAULT = 256;
   localparam int TOK_DEPTH       = 4;
   localparam int RSP_DEPTH       = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_MARKER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_END_CODE  = 2'd2;

   // register reset values
   localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'hF0;
   localparam logic [BYTE_W-1:0] ESCAPE_MARKER_RST = 8'hF1;
   localparam logic [BYTE_W-1:0] ESC_END_CODE_RST  = 8'hF2;

   // frame status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ESCAPE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DANGLING   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CHECKSUM   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;

   // token passed from front to back
   typedef enum logic [1:0] {
      TOK_DATA,
      TOK_BAD_ESC,
      TOK_END
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type      kind;
      logic              dangling;
      logic [BYTE_W-1:0] data;
   } token_type;

   // result word
   typedef struct packed {
      logic [BYTE_W-1:0]   payload_byte;
      logic                frame_done;
      logic [STATUS_W-1:0] frame_status;
      logic [LEN_W-1:0]    payload_length;
   } rsp_type;

endpackage

### hdl/stuffed_frame_decoder.sv
// ----------------------------------------------------------------------------
// stuffed_frame_decoder
// Byte-stuffing deframer with an additive checksum, top level.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   req     | req_rx_byte                             | push / full
//   rsp     | rsp_payload_byte, rsp_frame_done,       | empty / pop
//           | rsp_frame_status, rsp_payload_length    |
//   csr     | csr_index, csr_wdata                    | csr_valid / csr_ready
//
// One link byte per cycle is taken while full is low; the front classifies it in
// the cycle it is pushed and the back consumes one token per cycle from a 4-word
// queue while the result queue has room. Result words are registered in the result queue before rsp.
// Reset is synchronous; no clearing pass, csr_ready is always high.
// A stalled rsp side fills the result queue, then the token queue, then
// raises full.
// ----------------------------------------------------------------------------
module stuffed_frame_decoder #(
   parameter int MAX_LEN = sfd_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // input words
   input  logic                          push,
   output logic                          full,
   input  logic [sfd_pkg::BYTE_W-1:0]    req_rx_byte,
   // result words
   output logic                          empty,
   input  logic                          pop,
   output logic [sfd_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                          rsp_frame_done,
   output logic [sfd_pkg::STATUS_W-1:0]  rsp_frame_status,
   output logic [sfd_pkg::LEN_W-1:0]     rsp_payload_length,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfd_pkg::BYTE_W-1:0]    csr_wdata
);
   import sfd_pkg::*;

   localparam int TOK_W = $bits(token_type);
   localparam int RSP_W = $bits(rsp_type);

   logic      tok_push, tok_full, tok_pop, tok_empty;
   token_type tok_wr, tok_rd;
   logic      rsp_push, rsp_full;
   rsp_type   rsp_wr, rsp_rd;

   assign csr_ready = 1'b1;

   // front: markers and escape decode
   sfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (push),
      .in_byte  (req_rx_byte),
      .csr_we   (csr_valid & csr_ready),
      .csr_idx  (csr_index),
      .csr_data (csr_wdata),
      .tok_full (tok_full),
      .tok_push (tok_push),
      .tok      (tok_wr)
   );

   assign full = tok_full;

   // token queue between front and back
   sfd_fifo #(
      .WIDTH (TOK_W),
      .DEPTH (TOK_DEPTH)
   ) u_tok_q (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (tok_wr),
      .full      (tok_full),
      .pop       (tok_pop),
      .pop_data  (tok_rd),
      .empty     (tok_empty)
   );

   // back: frame accounting
   sfd_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_empty (tok_empty),
      .tok       (tok_rd),
      .tok_pop   (tok_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   // result queue
   sfd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_rd),
      .empty     (empty)
   );

   assign rsp_payload_byte   = rsp_rd.payload_byte;
   assign rsp_frame_done     = rsp_rd.frame_done;
   assign rsp_frame_status   = rsp_rd.frame_status;
   assign rsp_payload_length = rsp_rd.payload_length;

endmodule

### hdl/sfd_fifo.sv
// ----------------------------------------------------------------------------
// sfd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module sfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill-count update with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Marker registers and escape tracking; turns link bytes into tokens.
// ----------------------------------------------------------------------------
module sfd_front (
   input  logic                          clock,
   input  logic                          reset,
   // link bytes
   input  logic                          in_push,
   input  logic [sfd_pkg::BYTE_W-1:0]    in_byte,
   // marker registers
   input  logic                          csr_we,
   input  logic [sfd_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [sfd_pkg::BYTE_W-1:0]    csr_data,
   // token queue side
   input  logic                          tok_full,
   output logic                          tok_push,
   output sfd_pkg::token_type            tok
);
   import sfd_pkg::*;

   logic [BYTE_W-1:0] end_marker_ff;
   logic [BYTE_W-1:0] escape_marker_ff;
   logic [BYTE_W-1:0] esc_end_code_ff;
   logic              esc_pending_ff, esc_pending_in;
   logic              accept;
   logic              tok_valid;

   assign accept   = in_push & ~tok_full;
   assign tok_push = accept & tok_valid;

   // classify one byte: end, escape start, escape pair, or plain data
   always_comb begin
      esc_pending_in = esc_pending_ff;
      tok_valid      = 1'b0;
      tok.kind       = TOK_DATA;
      tok.dangling   = esc_pending_ff;
      tok.data       = in_byte;
      if (in_byte == end_marker_ff) begin
         tok_valid      = 1'b1;
         tok.kind       = TOK_END;
         esc_pending_in = 1'b0;
      end else if (!esc_pending_ff) begin
         if (in_byte == escape_marker_ff) begin
            esc_pending_in = 1'b1;
         end else begin
            tok_valid = 1'b1;
         end
      end else begin
         esc_pending_in = 1'b0;
         tok_valid      = 1'b1;
         if (in_byte == escape_marker_ff) begin
            tok.data = escape_marker_ff;
         end else if (in_byte == esc_end_code_ff) begin
            tok.data = end_marker_ff;
         end else begin
            tok.kind = TOK_BAD_ESC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_pending_ff <= 1'b0;
      end else if (accept) begin
         esc_pending_ff <= esc_pending_in;
      end
   end

   // marker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_ff    <= END_MARKER_RST;
         escape_marker_ff <= ESCAPE_MARKER_RST;
         esc_end_code_ff  <= ESC_END_CODE_RST;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_END_MARKER:    end_marker_ff    <= csr_data;
            CSR_ESCAPE_MARKER: escape_marker_ff <= csr_data;
            CSR_ESC_END_CODE:  esc_end_code_ff  <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

### hdl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Frame accounting: held byte, checksum, length, error and frame-end word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_back #(
   parameter int MAX_LEN = sfd_pkg::MAX_LEN_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // token queue side
   input  logic               tok_empty,
   input  sfd_pkg::token_type tok,
   output logic               tok_pop,
   // result queue side
   input  logic               rsp_full,
   output logic               rsp_push,
   output sfd_pkg::rsp_type   rsp
);
   import sfd_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 2);
   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_LEN + 1);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]   held_ff, held_in;
   logic                held_valid_ff, held_valid_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic [CNT_W-1:0]    len_raw;
   logic                tok_is_end;

   // one token per cycle while the result queue has room
   assign tok_pop    = ~tok_empty & ~rsp_full;
   assign tok_is_end = (tok.kind == TOK_END);
   assign len_raw    = (count_ff != '0) ? count_ff - 1'b1 : '0;

   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      err_in        = err_ff;
      rsp_push      = 1'b0;
      rsp           = '0;
      if (tok_pop) begin
         case (tok.kind)
            TOK_DATA: begin
               if (err_ff != ST_OK) begin
                  // frame already failed: drop
               end else if (count_ff == CNT_SAT) begin
                  err_in = ST_TOO_LONG;
               end else begin
                  rsp.payload_byte = held_ff;
                  rsp_push         = held_valid_ff;
                  held_in          = tok.data;
                  held_valid_in    = 1'b1;
                  sum_in           = sum_ff + tok.data;
                  count_in         = count_ff + 1'b1;
               end
            end
            TOK_BAD_ESC: begin
               if (err_ff == ST_OK) begin
                  err_in = ST_BAD_ESCAPE;
               end
            end
            TOK_END: begin
               // frame-end word unless the frame was empty
               rsp_push = (count_ff != '0) | tok.dangling | (err_ff != ST_OK);
               rsp.frame_done     = 1'b1;
               rsp.payload_length = LEN_W'(len_raw);
               if (err_ff != ST_OK) begin
                  rsp.frame_status = err_ff;
               end else if (tok.dangling) begin
                  rsp.frame_status = ST_DANGLING;
               end else if (sum_ff != '0) begin
                  rsp.frame_status = ST_CHECKSUM;
               end else begin
                  rsp.frame_status = ST_OK;
               end
               count_in      = '0;
               sum_in        = '0;
               held_in       = '0;
               held_valid_in = 1'b0;
               err_in        = ST_OK;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         err_ff        <= ST_OK;
      end else begin
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         err_ff        <= err_in;
      end
   end

   // checks
   `SFD_ASSERT(a_count_sat, clock, reset, count_ff <= CNT_SAT, "byte count passed saturation")
   `SFD_ASSERT(a_held_count, clock, reset, held_valid_ff == (count_ff != '0), "held flag out of step with count")
   `SFD_ASSERT_NEXT(a_err_sticky, clock, reset, (err_ff != ST_OK) && !(tok_pop && tok_is_end), $stable(err_ff) && $stable(count_ff), "error or count moved inside failed frame")
   `SFD_ASSERT(a_push_room, clock, reset, !(rsp_push && rsp_full), "result pushed into full queue")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stuffed frame decoder. A short table of link
// bytes with hand-read results comes first, then framed traffic (stuffed
// payloads with checksums, broken escapes, dangling escapes, bad checksums,
// raw noise and frames past the length limit) under several marker settings.
// Table words are checked against the table, later words against a software
// deframer kept in step with the accepted link bytes. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import sfd_pkg::*;

   localparam int FRAME_MAX     = MAX_LEN_DEFAULT;
   localparam int SETTLE_CYCLES = 16;
   localparam int NUM_PHASES    = 11;
   localparam int PHASE_BYTES   = 60;
   localparam int LONG_PHASE    = 3;
   localparam int HOLD_EVERY    = 250;
   localparam int HOLD_CYCLES   = 40;
   localparam int MAX_PRINTS    = 40;
   localparam longint RUN_LIMIT_NS = 2_000_000;

   // index past the last register, the block must ignore it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum {FRM_GOOD, FRM_BAD_SUM, FRM_BAD_ESC, FRM_DANGLING, FRM_NOISE} frame_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   rx;
      logic                typed;
      logic                done;
      logic [BYTE_W-1:0]   pbyte;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    len;
   } dir_row_type;

   // directed bytes under the reset markers (end F0, escape F1, escaped end F2)
   localparam dir_row_type DIRECTED [25] = '{
      // zero payload byte, zero checksum
      '{8'h00, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'h00, 1'b1, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF0, 1'b1, 1'b1, 8'h00, ST_OK,       9'd1},
      // all-ones payload byte
      '{8'hFF, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'h01, 1'b1, 1'b0, 8'hFF, ST_OK,       9'd0},
      '{8'hF0, 1'b1, 1'b1, 8'h00, ST_OK,       9'd1},
      // literal escape and literal end bytes
      '{8'hF1, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF1, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF1, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF2, 1'b1, 1'b0, 8'hF1, ST_OK,       9'd0},
      '{8'h1F, 1'b1, 1'b0, 8'hF0, ST_OK,       9'd0},
      '{8'hF0, 1'b1, 1'b1, 8'h00, ST_OK,       9'd2},
      // end right after an escape
      '{8'hF1, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF0, 1'b1, 1'b1, 8'h00, ST_DANGLING, 9'd0},
      // bad escape, later bytes dropped
      '{8'h05, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF1, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'h33, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'h07, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF0, 1'b1, 1'b1, 8'h00, ST_BAD_ESCAPE, 9'd0},
      // checksum not zero
      '{8'h10, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF0, 1'b1, 1'b1, 8'h00, ST_CHECKSUM, 9'd0},
      // empty frame, nothing comes out
      '{8'hF0, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      // bad escape with nothing decoded still reports
      '{8'hF1, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'h33, 1'b0, 1'b0, 8'h00, ST_OK,       9'd0},
      '{8'hF0, 1'b1, 1'b1, 8'h00, ST_BAD_ESCAPE, 9'd0}
   };

   // marker settings: end, escape, escaped end
   localparam logic [BYTE_W-1:0] MARKER_SETS [8][3] = '{
      '{8'hF0, 8'hF1, 8'hF2},
      '{8'h00, 8'hFF, 8'h80},
      '{8'hFF, 8'h00, 8'h7F},
      '{8'h7E, 8'h7D, 8'h00},
      '{8'h01, 8'h02, 8'hFF},
      '{8'h55, 8'h55, 8'hAA},
      '{8'h10, 8'h20, 8'h20},
      '{8'h30, 8'h31, 8'h30}
   };

   logic                 clock;
   logic                 reset;
   logic                 push;
   logic                 full;
   logic [BYTE_W-1:0]    req_rx_byte;
   logic                 empty;
   logic                 pop;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic                 rsp_frame_done;
   logic [STATUS_W-1:0]  rsp_frame_status;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   stuffed_frame_decoder uut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_rx_byte        (req_rx_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // deframer copy: markers and per-frame state
   logic [BYTE_W-1:0]   end_mark;
   logic [BYTE_W-1:0]   esc_mark;
   logic [BYTE_W-1:0]   eec_mark;
   bit                  escape_pending;
   int unsigned         decoded_count;
   logic [BYTE_W-1:0]   running_sum;
   logic [BYTE_W-1:0]   held_byte;
   bit                  held_ok;
   logic [STATUS_W-1:0] frame_err;

   // words the decoder still owes, oldest first
   rsp_type deframed_q [$];

   int  mismatch_count;
   int  bytes_sent;
   int  words_taken;
   int  marker_sets_used;
   int  status_seen [5];
   bit  burst_mode;

   function automatic void clear_frame();
      escape_pending = 1'b0;
      decoded_count  = 0;
      running_sum    = '0;
      held_byte      = '0;
      held_ok        = 1'b0;
      frame_err      = ST_OK;
   endfunction

   // one decoded byte enters the frame; the previously held one is released
   function automatic bit take_decoded(input logic [BYTE_W-1:0] d, output rsp_type w);
      w = '0;
      if (frame_err != ST_OK)
         return 1'b0;
      if (decoded_count >= FRAME_MAX + 1) begin
         frame_err = ST_TOO_LONG;
         return 1'b0;
      end
      take_decoded = held_ok;
      w.payload_byte = held_byte;
      held_byte = d;
      held_ok = 1'b1;
      running_sum = running_sum + d;
      decoded_count++;
   endfunction

   // word the decoder gives for one link byte, if any
   function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output rsp_type w);
      logic [STATUS_W-1:0] status;
      w = '0;
      if (b == end_mark) begin
         if (decoded_count == 0 && !escape_pending && frame_err == ST_OK) begin
            clear_frame();
            return 1'b0;
         end
         if (frame_err != ST_OK)
            status = frame_err;
         else if (escape_pending)
            status = ST_DANGLING;
         else if (running_sum != 0)
            status = ST_CHECKSUM;
         else
            status = ST_OK;
         w.frame_done = 1'b1;
         w.frame_status = status;
         w.payload_length = (decoded_count > 0) ? LEN_W'(decoded_count - 1) : '0;
         clear_frame();
         return 1'b1;
      end
      if (!escape_pending) begin
         if (b == esc_mark) begin
            escape_pending = 1'b1;
            return 1'b0;
         end
         return take_decoded(b, w);
      end
      escape_pending = 1'b0;
      if (b == esc_mark)
         return take_decoded(esc_mark, w);
      if (b == eec_mark)
         return take_decoded(end_mark, w);
      if (frame_err == ST_OK)
         frame_err = ST_BAD_ESCAPE;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // offer one link byte until taken, then update the expected words
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                            input rsp_type typed_word = '0);
      int      gap;
      bit      have;
      rsp_type w;
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      bytes_sent++;
      have = deframe_byte(b, w);
      if (typed)
         deframed_q.push_back(typed_word);
      else if (have)
         deframed_q.push_back(w);
   endtask

   // stop offering, let every owed word out, then let the pipe settle
   task automatic wait_idle();
      push <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write; valid is left high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_END_MARKER:    end_mark = val;
         CSR_ESCAPE_MARKER: esc_mark = val;
         CSR_ESC_END_CODE:  eec_mark = val;
         default: ;
      endcase
   endtask

   task automatic apply_markers(input logic [BYTE_W-1:0] e, input logic [BYTE_W-1:0] s,
                                input logic [BYTE_W-1:0] c);
      write_reg(CSR_SPARE, BYTE_W'($urandom_range(0, 255)));
      write_reg(CSR_END_MARKER, e);
      write_reg(CSR_ESCAPE_MARKER, s);
      write_reg(CSR_ESC_END_CODE, c);
      csr_valid <= 1'b0;
      marker_sets_used++;
   endtask

   // random byte, leaning toward the current markers
   function automatic logic [BYTE_W-1:0] pick_link_byte(input int marker_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < marker_pct) begin
         case ($urandom_range(0, 2))
            0: return end_mark;
            1: return esc_mark;
            default: return eec_mark;
         endcase
      end
      if (r < marker_pct + 5)
         return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // stuff one decoded byte onto the link
   task automatic send_stuffed(input logic [BYTE_W-1:0] d);
      if (d == end_mark) begin
         send_byte(esc_mark);
         send_byte(eec_mark);
      end else if (d == esc_mark) begin
         send_byte(esc_mark);
         send_byte(esc_mark);
      end else begin
         send_byte(d);
      end
   endtask

   // payload plus checksum, stuffed and closed, with the chosen defect
   task automatic send_frame(input int n_payload, input frame_kind_type kind);
      logic [BYTE_W-1:0] data [$];
      logic [BYTE_W-1:0] csum;
      logic [BYTE_W-1:0] b;
      int                bad_at;
      if (kind == FRM_NOISE) begin
         repeat ($urandom_range(1, 8)) send_byte(pick_link_byte(50));
         return;
      end
      csum = '0;
      for (int i = 0; i < n_payload; i++) begin
         b = pick_link_byte(25);
         data.push_back(b);
         csum = csum + b;
      end
      csum = ~csum + 8'd1;
      if (kind == FRM_BAD_SUM)
         csum = csum + BYTE_W'($urandom_range(1, 255));
      data.push_back(csum);
      bad_at = $urandom_range(0, data.size());
      for (int i = 0; i <= data.size(); i++) begin
         if (kind == FRM_BAD_ESC && i == bad_at) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == esc_mark || b == eec_mark || b == end_mark)
               b = b ^ 8'h0C;
            send_byte(esc_mark);
            send_byte(b);
         end
         if (i < data.size())
            send_stuffed(data[i]);
      end
      if (kind == FRM_DANGLING)
         send_byte(esc_mark);
      send_byte(end_mark);
   endtask

   // stimulus
   initial begin : link_side
      int             r;
      int             phase_end;
      int             n;
      frame_kind_type kind;
      reset       <= 1'b1;
      push        <= 1'b0;
      req_rx_byte <= '0;
      pop         <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_END_MARKER;
      csr_wdata   <= '0;
      end_mark = END_MARKER_RST;
      esc_mark = ESCAPE_MARKER_RST;
      eec_mark = ESC_END_CODE_RST;
      clear_frame();
      burst_mode = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table under reset markers
      foreach (DIRECTED[i])
         send_byte(DIRECTED[i].rx, DIRECTED[i].typed,
                   '{DIRECTED[i].pbyte, DIRECTED[i].done, DIRECTED[i].status,
                     DIRECTED[i].len});

      // random frames, one marker setting per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         if (p < 8)
            apply_markers(MARKER_SETS[p][0], MARKER_SETS[p][1], MARKER_SETS[p][2]);
         else
            apply_markers(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                          BYTE_W'($urandom_range(0, 255)));
         burst_mode = (p % 3 == 1);
         // right at the length limit, then one past it
         if (p == LONG_PHASE) begin
            send_frame(FRAME_MAX, FRM_GOOD);
            send_frame(FRAME_MAX + 1, FRM_GOOD);
         end
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) begin
            r = $urandom_range(0, 99);
            kind = (r < 60) ? FRM_GOOD : (r < 70) ? FRM_BAD_SUM : (r < 80) ? FRM_BAD_ESC :
                   (r < 88) ? FRM_DANGLING : FRM_NOISE;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            send_frame(n, kind);
         end
      end

      wait_idle();
      $display("covered %0d link bytes, %0d result words, %0d marker settings",
               bytes_sent, words_taken, marker_sets_used);
      $display("frame ends: ok %0d, bad escape %0d, dangling %0d, checksum %0d, too long %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (mismatch_count == 0)
         $display("[stuffed_frame_decoder] OK");
      else
         $display("[stuffed_frame_decoder] ERROR");
      $finish;
   end

   // result side: random stalls, a long hold now and then
   initial begin : rsp_side
      int      stall;
      rsp_type got;
      rsp_type want;
      wait (reset === 1'b0);
      forever begin
         if (words_taken % HOLD_EVERY == HOLD_EVERY - 1)
            stall = HOLD_CYCLES;
         else if ((words_taken / 100) % 2 == 1)
            stall = 0;
         else
            stall = $urandom_range(0, 3);
         if (stall != 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         words_taken++;
         got = '{rsp_payload_byte, rsp_frame_done, rsp_frame_status, rsp_payload_length};
         if (deframed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got));
         end else begin
            want = deframed_q.pop_front();
            if (got.frame_done !== want.frame_done)
               report_mismatch($sformatf("frame_done %b, want %b", got.frame_done,
                                         want.frame_done));
            if (got.payload_byte !== want.payload_byte)
               report_mismatch($sformatf("payload_byte %h, want %h", got.payload_byte,
                                         want.payload_byte));
            if (got.frame_status !== want.frame_status)
               report_mismatch($sformatf("frame_status %0d, want %0d", got.frame_status,
                                         want.frame_status));
            if (got.payload_length !== want.payload_length)
               report_mismatch($sformatf("payload_length %0d, want %0d", got.payload_length,
                                         want.payload_length));
            if (want.frame_done && want.frame_status <= ST_TOO_LONG)
               status_seen[want.frame_status]++;
         end
      end
   end

   // watchdog
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("timeout with %0d words still owed", deframed_q.size());
      $display("[stuffed_frame_decoder] ERROR");
      $finish;
   end

endmodule
